FILE: hdl/rgcd_pkg.sv
// Shared types, constants and reset values for the RSSI gate crossing detector.
package rgcd_pkg;

	localparam int SETTLE_MS_DEF = 35;
	localparam int DURATION_BITS_DEF = 16;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTER_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LEVEL = 1'b1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RETUNE = 1'b1;

	localparam logic [7:0] ENTER_LEVEL_RST = 8'd96;
	localparam logic [7:0] EXIT_LEVEL_RST = 8'd80;
	localparam logic [7:0] LEVEL_MIN = 8'd0;
	localparam logic [7:0] LEVEL_MAX = 8'd255;

	typedef struct packed {
		logic        in_crossing;
		logic        need_settle;
		logic [31:0] reset_stamp;
		logic [7:0]  pk_level;
		logic [31:0] pk_start;
		logic [7:0]  low_level;
		logic [7:0]  laps;
		logic [7:0]  last_peak;
		logic [31:0] last_mid;
		logic [7:0]  last_low;
		logic [7:0]  life_peak;
		logic [7:0]  life_low;
	} stat_t;

	localparam stat_t STAT_RST = '{
		in_crossing: 1'b0,
		need_settle: 1'b1,
		reset_stamp: 32'd0,
		pk_level:    LEVEL_MIN,
		pk_start:    32'd0,
		low_level:   LEVEL_MAX,
		laps:        8'd0,
		last_peak:   8'd0,
		last_mid:    32'd0,
		last_low:    8'd0,
		life_peak:   LEVEL_MIN,
		life_low:    LEVEL_MAX
	};

	typedef struct packed {
		logic        crossing_now;
		logic        lap_done;
		logic [7:0]  lap_count;
		logic [7:0]  lap_peak;
		logic [31:0] lap_time;
		logic [7:0]  lap_nadir;
		logic [7:0]  node_peak;
		logic [7:0]  node_nadir;
		logic        settled;
	} rsp_item_t;

endpackage

FILE: hdl/rgcd_req_if.sv
// Request channel interface carrying samples and retune commands.
interface rgcd_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  rssi_level;
	logic [31:0] time_ms;

	modport source (output valid, output opcode, output rssi_level, output time_ms,
		input ready);
	modport sink (input valid, input opcode, input rssi_level, input time_ms,
		output ready);
endinterface

FILE: hdl/rgcd_rsp_if.sv
// Response channel interface carrying the detector status after each request.
interface rgcd_rsp_if;
	logic        valid;
	logic        ready;
	logic        crossing_now;
	logic        lap_done;
	logic [7:0]  lap_count;
	logic [7:0]  lap_peak;
	logic [31:0] lap_time;
	logic [7:0]  lap_nadir;
	logic [7:0]  node_peak;
	logic [7:0]  node_nadir;
	logic        settled;

	modport source (output valid, output crossing_now, output lap_done, output lap_count,
		output lap_peak, output lap_time, output lap_nadir, output node_peak,
		output node_nadir, output settled, input ready);
	modport sink (input valid, input crossing_now, input lap_done, input lap_count,
		input lap_peak, input lap_time, input lap_nadir, input node_peak,
		input node_nadir, input settled, output ready);
endinterface

FILE: hdl/rssi_gate_crossing_detector.sv
// Top level of the RSSI gate crossing detector with enter/exit hysteresis.
// Latency: the response to a request is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken; a response that is held
// off keeps request ready low, and the next request enters in the cycle it leaves.
// Reset: arst_n clears the statistics, sets the settle wait and restores the
// enter and exit levels to 96 and 80; no response is pending after reset.
module rssi_gate_crossing_detector #(
	parameter int SETTLE_MS = rgcd_pkg::SETTLE_MS_DEF,
	parameter int DURATION_BITS = rgcd_pkg::DURATION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rgcd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rgcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	rgcd_req_if.sink                         req,
	rgcd_rsp_if.source                       rsp
);
	import rgcd_pkg::*;

	logic [7:0]               enter_q;
	logic [7:0]               exit_q;
	stat_t                    stat_q;
	logic [DURATION_BITS-1:0] len_q;
	rsp_item_t                rsp_q;
	logic                     rsp_vld_q;

	stat_t                    nxt;
	logic [DURATION_BITS-1:0] nxt_len;
	logic                     ended;
	logic                     req_acc;

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign req_acc = req.valid && req.ready;

	rgcd_step #(
		.SETTLE_MS(SETTLE_MS),
		.DURATION_BITS(DURATION_BITS)
	) u_step (
		.cur(stat_q),
		.cur_len(len_q),
		.opcode(req.opcode),
		.rssi_level(req.rssi_level),
		.time_ms(req.time_ms),
		.enter_level(enter_q),
		.exit_level(exit_q),
		.nxt(nxt),
		.nxt_len(nxt_len),
		.ended(ended)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= ENTER_LEVEL_RST;
			exit_q <= EXIT_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ENTER_LEVEL: enter_q <= cfg_data;
				CFG_EXIT_LEVEL: exit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= STAT_RST;
			len_q <= '0;
			rsp_vld_q <= 1'b0;
		end else if (req_acc) begin
			stat_q <= nxt;
			len_q <= nxt_len;
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			rsp_q.crossing_now <= nxt.in_crossing;
			rsp_q.lap_done <= ended;
			rsp_q.lap_count <= nxt.laps;
			rsp_q.lap_peak <= nxt.last_peak;
			rsp_q.lap_time <= nxt.last_mid;
			rsp_q.lap_nadir <= nxt.last_low;
			rsp_q.node_peak <= nxt.life_peak;
			rsp_q.node_nadir <= nxt.life_low;
			rsp_q.settled <= !nxt.need_settle;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.crossing_now = rsp_q.crossing_now;
	assign rsp.lap_done = rsp_q.lap_done;
	assign rsp.lap_count = rsp_q.lap_count;
	assign rsp.lap_peak = rsp_q.lap_peak;
	assign rsp.lap_time = rsp_q.lap_time;
	assign rsp.lap_nadir = rsp_q.lap_nadir;
	assign rsp.node_peak = rsp_q.node_peak;
	assign rsp.node_nadir = rsp_q.node_nadir;
	assign rsp.settled = rsp_q.settled;

	// A request that closes a lap bumps the lap count by exactly one.
	a_lap_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && ended |=> stat_q.laps == $past(stat_q.laps) + 8'd1)
		else $error("lap count did not advance on a completed lap");

	// No crossing can be open while the settle wait is pending.
	a_no_cross_unsettled: assert property (@(posedge clk) disable iff (!arst_n)
		stat_q.need_settle |-> !stat_q.in_crossing)
		else $error("crossing open during settle wait");

	// Lifetime statistics stay at their cleared values until the wait has passed.
	a_life_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		stat_q.need_settle |-> stat_q.life_peak == LEVEL_MIN
			&& stat_q.life_low == LEVEL_MAX)
		else $error("lifetime statistics changed during settle wait");

	// A response that reports a finished lap never shows a crossing in progress.
	a_done_not_crossing: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.lap_done |-> !rsp_q.crossing_now)
		else $error("lap done reported while still crossing");
endmodule

FILE: hdl/rgcd_step.sv
// Next-state logic of the detector for one request.
module rgcd_step #(
	parameter int SETTLE_MS = rgcd_pkg::SETTLE_MS_DEF,
	parameter int DURATION_BITS = rgcd_pkg::DURATION_BITS_DEF
) (
	input  rgcd_pkg::stat_t           cur,
	input  logic [DURATION_BITS-1:0]  cur_len,
	input  logic                      opcode,
	input  logic [7:0]                rssi_level,
	input  logic [31:0]               time_ms,
	input  logic [7:0]                enter_level,
	input  logic [7:0]                exit_level,
	output rgcd_pkg::stat_t           nxt,
	output logic [DURATION_BITS-1:0]  nxt_len,
	output logic                      ended
);
	import rgcd_pkg::*;

	localparam logic [31:0] DUR_LIM = 32'((64'd1 << DURATION_BITS) - 64'd1);
	localparam logic [31:0] SETTLE_LIM = 32'(SETTLE_MS);

	logic [31:0]              peak_d;
	logic [DURATION_BITS-1:0] peak_sat;
	logic [31:0]              settle_d;
	logic [31:0]              mid_time;

	assign peak_d = time_ms - cur.pk_start;
	assign peak_sat = (peak_d > DUR_LIM) ? DUR_LIM[DURATION_BITS-1:0]
		: peak_d[DURATION_BITS-1:0];
	assign settle_d = time_ms - cur.reset_stamp;
	assign mid_time = cur.pk_start + 32'(cur_len >> 1);

	always_comb begin
		nxt = cur;
		nxt_len = cur_len;
		ended = 1'b0;
		if (opcode == OP_RETUNE) begin
			nxt.in_crossing = 1'b0;
			nxt.pk_level = LEVEL_MIN;
			nxt.pk_start = 32'd0;
			nxt_len = '0;
			nxt.low_level = LEVEL_MAX;
			nxt.life_peak = LEVEL_MIN;
			nxt.life_low = LEVEL_MAX;
			nxt.need_settle = 1'b1;
			nxt.reset_stamp = time_ms;
		end else begin
			if (!cur.need_settle) begin
				if (rssi_level > cur.life_peak) begin
					nxt.life_peak = rssi_level;
				end
				if (rssi_level < cur.life_low) begin
					nxt.life_low = rssi_level;
				end
				if (!cur.in_crossing && rssi_level >= enter_level) begin
					nxt.in_crossing = 1'b1;
				end else if (cur.in_crossing && rssi_level < exit_level) begin
					nxt.last_peak = cur.pk_level;
					nxt.last_mid = mid_time;
					nxt.last_low = cur.low_level;
					nxt.laps = cur.laps + 8'd1;
					nxt.in_crossing = 1'b0;
					nxt.pk_level = LEVEL_MIN;
					nxt.pk_start = 32'd0;
					nxt_len = '0;
					nxt.low_level = LEVEL_MAX;
					ended = 1'b1;
				end
				// The pass is only cleared on the ending path, where tracking
				// takes the low branch, so peak_sat from the current start holds.
				if (nxt.in_crossing) begin
					if (rssi_level > nxt.pk_level) begin
						nxt.pk_level = rssi_level;
						nxt.pk_start = time_ms;
						nxt_len = '0;
					end else if (rssi_level == nxt.pk_level) begin
						nxt_len = peak_sat;
					end
				end else if (rssi_level < nxt.low_level) begin
					nxt.low_level = rssi_level;
				end
			end
			if (cur.need_settle && settle_d >= SETTLE_LIM) begin
				nxt.need_settle = 1'b0;
			end
		end
	end
endmodule

FILE: tb/rssi_gate_crossing_detector_test.sv
// Self-checking testbench for the RSSI gate crossing detector: predicted status per request.
module rssi_gate_crossing_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rgcd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam logic [31:0] DUR_MAX = (32'd1 << DURATION_BITS_DEF) - 32'd1;

	class crossing_predictor;
		logic [7:0] enter_lvl;
		logic [7:0] exit_lvl;
		logic in_cross;
		logic need_settle;
		logic [31:0] tune_stamp;
		logic [7:0] pk_level;
		logic [31:0] pk_start;
		logic [DURATION_BITS_DEF-1:0] pk_len;
		logic [7:0] low_level;
		logic [7:0] laps;
		logic [7:0] last_peak;
		logic [31:0] last_mid;
		logic [7:0] last_low;
		logic [7:0] life_peak;
		logic [7:0] life_low;
		rsp_item_t expected_status[$];
		int errors;

		function new();
			enter_lvl = ENTER_LEVEL_RST;
			exit_lvl = EXIT_LEVEL_RST;
			clear_pass();
			need_settle = 1'b1;
			tune_stamp = '0;
			laps = '0;
			last_peak = '0;
			last_mid = '0;
			last_low = '0;
			life_peak = LEVEL_MIN;
			life_low = LEVEL_MAX;
			errors = 0;
		endfunction

		function void clear_pass();
			in_cross = 1'b0;
			pk_level = LEVEL_MIN;
			pk_start = '0;
			pk_len = '0;
			low_level = LEVEL_MAX;
		endfunction

		function void set_level(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			if (idx == CFG_ENTER_LEVEL) begin
				enter_lvl = value;
			end else begin
				exit_lvl = value;
			end
		endfunction

		function void accept_request(logic op, logic [7:0] lvl, logic [31:0] stamp);
			rsp_item_t e;
			logic [31:0] held;
			logic [31:0] waited;
			logic ended;
			ended = 1'b0;
			if (op == OP_RETUNE) begin
				clear_pass();
				life_peak = LEVEL_MIN;
				life_low = LEVEL_MAX;
				need_settle = 1'b1;
				tune_stamp = stamp;
			end else begin
				if (!need_settle) begin
					if (lvl > life_peak) life_peak = lvl;
					if (lvl < life_low) life_low = lvl;
					if (!in_cross && lvl >= enter_lvl) begin
						in_cross = 1'b1;
					end else if (in_cross && lvl < exit_lvl) begin
						last_peak = pk_level;
						last_mid = pk_start + 32'(pk_len >> 1);
						last_low = low_level;
						laps = laps + 8'd1;
						clear_pass();
						ended = 1'b1;
					end
					if (in_cross) begin
						if (lvl > pk_level) begin
							pk_level = lvl;
							pk_start = stamp;
							pk_len = '0;
						end else if (lvl == pk_level) begin
							held = stamp - pk_start;
							pk_len = DURATION_BITS_DEF'((held > DUR_MAX) ? DUR_MAX : held);
						end
					end else if (lvl < low_level) begin
						low_level = lvl;
					end
				end
				waited = stamp - tune_stamp;
				if (need_settle && waited >= 32'(SETTLE_MS_DEF)) need_settle = 1'b0;
			end
			e.crossing_now = in_cross;
			e.lap_done = ended;
			e.lap_count = laps;
			e.lap_peak = last_peak;
			e.lap_time = last_mid;
			e.lap_nadir = last_low;
			e.node_peak = life_peak;
			e.node_nadir = life_low;
			e.settled = !need_settle;
			expected_status.push_back(e);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_status(rsp_item_t got);
			rsp_item_t e;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: status arrived with no request outstanding, actual %h",
					$time, got);
				return;
			end
			e = expected_status.pop_front();
			compare("crossing_now", 32'(e.crossing_now), 32'(got.crossing_now));
			compare("lap_done", 32'(e.lap_done), 32'(got.lap_done));
			compare("lap_count", 32'(e.lap_count), 32'(got.lap_count));
			compare("lap_peak", 32'(e.lap_peak), 32'(got.lap_peak));
			compare("lap_time", e.lap_time, got.lap_time);
			compare("lap_nadir", 32'(e.lap_nadir), 32'(got.lap_nadir));
			compare("node_peak", 32'(e.node_peak), 32'(got.node_peak));
			compare("node_nadir", 32'(e.node_nadir), 32'(got.node_nadir));
			compare("settled", 32'(e.settled), 32'(got.settled));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rgcd_req_if req_ch();
	rgcd_rsp_if rsp_ch();

	rssi_gate_crossing_detector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	crossing_predictor sb = new();

	bit no_gaps;
	bit long_hold;
	int cur_enter;
	int cur_exit;
	int sent_count;
	int quiet_cycles;
	logic [31:0] now_ms;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		rsp_item_t got;
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				stall = LONG_HOLD_CYCLES;
				long_hold = 1'b0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 8);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got.crossing_now = rsp_ch.crossing_now;
			got.lap_done = rsp_ch.lap_done;
			got.lap_count = rsp_ch.lap_count;
			got.lap_peak = rsp_ch.lap_peak;
			got.lap_time = rsp_ch.lap_time;
			got.lap_nadir = rsp_ch.lap_nadir;
			got.node_peak = rsp_ch.node_peak;
			got.node_nadir = rsp_ch.node_nadir;
			got.settled = rsp_ch.settled;
			sb.check_status(got);
		end
	end

	task automatic send_request(logic op, logic [7:0] lvl, logic [31:0] stamp);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.rssi_level <= lvl;
		req_ch.time_ms <= stamp;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.accept_request(op, lvl, stamp);
		sent_count++;
	endtask

	function automatic logic [31:0] next_stamp();
		case ($urandom_range(0, 31))
			0: now_ms = $urandom;
			1: now_ms = now_ms + 32'd70000;
			2, 3, 4: now_ms = now_ms;
			default: now_ms = now_ms + 32'($urandom_range(1, 40));
		endcase
		return now_ms;
	endfunction

	task automatic sample(logic [7:0] lvl);
		send_request(OP_SAMPLE, lvl, next_stamp());
	endtask

	task automatic settle_down();
		req_ch.valid <= 1'b0;
		while (sb.expected_status.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_levels(logic [7:0] enter_value, logic [7:0] exit_value);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_ENTER_LEVEL;
		cfg_data <= enter_value;
		@(posedge clk);
		cfg_idx <= CFG_EXIT_LEVEL;
		cfg_data <= exit_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_level(CFG_ENTER_LEVEL, enter_value);
		sb.set_level(CFG_EXIT_LEVEL, exit_value);
		cur_enter = enter_value;
		cur_exit = exit_value;
	endtask

	// Mostly complete passes: quiet floor, rise, a plateau with repeated peaks, then a drop.
	task automatic run_passes(int n_items);
		int target;
		logic [7:0] top;
		logic [7:0] base;
		target = sent_count + n_items;
		while (sent_count < target) begin
			case ($urandom_range(0, 11))
				0: send_request(OP_RETUNE, 8'($urandom), next_stamp());
				1: sample(8'($urandom));
				default: begin
					top = 8'($urandom_range(cur_enter, 255));
					base = (cur_exit > 0) ? 8'($urandom_range(0, cur_exit - 1)) : 8'd0;
					repeat ($urandom_range(1, 3)) sample(8'($urandom_range(0, base)));
					repeat ($urandom_range(0, 2)) sample(8'($urandom_range(base, top)));
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 2) == 0 && top > 0) begin
							sample(top - 8'd1);
						end else begin
							sample(top);
						end
					end
					sample(base);
				end
			endcase
		end
	endtask

	initial begin
		int enter_pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_ENTER_LEVEL;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_SAMPLE;
		req_ch.rssi_level = '0;
		req_ch.time_ms = '0;
		rsp_ch.ready = 1'b0;
		no_gaps = 1'b0;
		long_hold = 1'b0;
		sent_count = 0;
		quiet_cycles = 0;
		cur_enter = ENTER_LEVEL_RST;
		cur_exit = EXIT_LEVEL_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_SAMPLE, 8'd200, 32'd0);
		send_request(OP_SAMPLE, 8'd10, 32'd34);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'd35);
		send_request(OP_SAMPLE, LEVEL_MIN, 32'd40);
		send_request(OP_SAMPLE, 8'd96, 32'd50);
		send_request(OP_SAMPLE, 8'd96, 32'd60);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'd70);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'd100070);
		send_request(OP_SAMPLE, 8'd80, 32'd100080);
		send_request(OP_SAMPLE, 8'd79, 32'd100090);
		send_request(OP_RETUNE, LEVEL_MAX, 32'hFFFF_FFF0);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'h0000_0012);
		send_request(OP_SAMPLE, LEVEL_MIN, 32'h0000_0013);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'h0000_0020);
		send_request(OP_SAMPLE, LEVEL_MIN, 32'h0000_0030);
		settle_down();

		// With both levels at zero the first crossing sample matches the cleared peak.
		program_levels(8'd0, 8'd0);
		send_request(OP_SAMPLE, LEVEL_MIN, 32'd100);
		send_request(OP_SAMPLE, LEVEL_MIN, 32'd110);
		send_request(OP_SAMPLE, LEVEL_MAX, 32'd120);
		settle_down();

		program_levels(8'd10, 8'd200);
		send_request(OP_SAMPLE, 8'd50, 32'd200);
		send_request(OP_SAMPLE, 8'd50, 32'd210);
		send_request(OP_SAMPLE, 8'd5, 32'd220);
		now_ms = 32'd220;

		for (int phase = 0; phase < 9; phase++) begin
			settle_down();
			case (phase)
				0: program_levels(ENTER_LEVEL_RST, EXIT_LEVEL_RST);
				1: program_levels(LEVEL_MAX, LEVEL_MAX);
				2: program_levels(LEVEL_MIN, LEVEL_MIN);
				3: program_levels(LEVEL_MIN, LEVEL_MAX);
				4: program_levels(LEVEL_MAX, LEVEL_MIN);
				8: program_levels(8'($urandom), 8'($urandom));
				default: begin
					enter_pick = $urandom_range(1, 255);
					program_levels(8'(enter_pick), 8'($urandom_range(0, enter_pick)));
				end
			endcase
			no_gaps = (phase == 5 || phase == 6);
			long_hold = (phase == 6);
			run_passes(48);
		end

		no_gaps = 1'b0;
		settle_down();
		if (sb.errors == 0 && sb.expected_status.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

FILE: filelist.f
hdl/rgcd_pkg.sv
hdl/rgcd_req_if.sv
hdl/rgcd_rsp_if.sv
hdl/rgcd_step.sv
hdl/rssi_gate_crossing_detector.sv
tb/rssi_gate_crossing_detector_test.sv
